[rtl/core/jcfe_pkg.sv]
// Package for the JSON content field extractor.
// Holds the parser phase type, outcome codes, key constants and the
// structs passed between the parser, the result queue and the top level.
`default_nettype none

package jcfe_pkg;

	typedef enum logic [2:0] {
		PH_KEY    = 3'd0,
		PH_COLON  = 3'd1,
		PH_QUOTE  = 3'd2,
		PH_STRING = 3'd3,
		PH_DONE   = 3'd4
	} phase_t;

	typedef enum logic [1:0] {
		OC_FOUND   = 2'd0,
		OC_MISSING = 2'd1,
		OC_EMPTY   = 2'd2
	} outcome_t;

	// Last eight bytes of the quoted key, newest in the low byte.
	localparam logic [63:0] KEY_TAIL8 = 64'h636F_6E74_656E_7422;
	localparam logic [7:0]  CH_QUOTE  = 8'h22;
	localparam logic [7:0]  CH_COLON  = 8'h3A;
	localparam logic [7:0]  CH_BSLASH = 8'h5C;
	localparam logic [7:0]  CH_N      = 8'h6E;
	localparam logic [7:0]  CH_R      = 8'h72;
	localparam logic [7:0]  CH_T      = 8'h74;
	localparam logic [7:0]  CH_LF     = 8'h0A;
	localparam logic [7:0]  CH_CR     = 8'h0D;
	localparam logic [7:0]  CH_TAB    = 8'h09;

	localparam int QDEPTH = 4;
	localparam int QIDX_W = 2;
	localparam int QCNT_W = 3;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       end_mark;
		outcome_t   outcome;
	} result_t;

	// Up to two results per input word: a content byte, then an end marker.
	typedef struct packed {
		logic       content_valid;
		logic [7:0] content_byte;
		logic       end_valid;
		outcome_t   outcome;
	} push_t;

	typedef struct packed {
		logic [QCNT_W-1:0] count;
		logic              room;
	} qstat_t;

endpackage

`default_nettype wire

[rtl/core/jcfe_parser.sv]
// Parser state and next-state logic for the content field extractor.
// Depends on jcfe_pkg; produces the results of one word per advance.
`default_nettype none

module jcfe_parser import jcfe_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       advance,
	input  wire logic [7:0] byte_in,
	input  wire logic       last_in,
	output push_t           push
);

	logic [63:0] recent_q;
	phase_t      phase_q;
	logic        esc_q;
	logic        any_q;

	phase_t      phase_d;
	logic        esc_d;
	logic        any_d;
	logic        key_hit;
	logic [7:0]  mapped;

	assign key_hit = ({recent_q[55:0], byte_in} == KEY_TAIL8) &&
			(recent_q[63:56] == CH_QUOTE);

	always_comb begin
		case (byte_in)
			CH_N:    mapped = CH_LF;
			CH_R:    mapped = CH_CR;
			CH_T:    mapped = CH_TAB;
			default: mapped = byte_in;
		endcase
	end

	// Next phase.
	always_comb begin
		phase_d = phase_q;
		case (phase_q)
			PH_KEY:    if (key_hit) phase_d = PH_COLON;
			PH_COLON:  if (byte_in == CH_COLON) phase_d = PH_QUOTE;
			PH_QUOTE:  if (byte_in == CH_QUOTE) phase_d = PH_STRING;
			PH_STRING: if (!esc_q && byte_in == CH_QUOTE) phase_d = PH_DONE;
			default:   phase_d = phase_q;
		endcase
	end

	// Emitted content byte, escape tracking, end marker and outcome code.
	always_comb begin
		esc_d = esc_q;
		any_d = any_q;
		push.content_valid = 1'b0;
		push.content_byte  = byte_in;
		if (phase_q == PH_STRING) begin
			if (esc_q) begin
				push.content_valid = 1'b1;
				push.content_byte  = mapped;
				esc_d = 1'b0;
				any_d = 1'b1;
			end else if (byte_in == CH_BSLASH) begin
				esc_d = 1'b1;
			end else if (byte_in != CH_QUOTE) begin
				push.content_valid = 1'b1;
				any_d = 1'b1;
			end
		end
		push.end_valid = last_in;
		if (phase_d == PH_KEY || phase_d == PH_COLON || phase_d == PH_QUOTE) begin
			push.outcome = OC_MISSING;
		end else if (any_d) begin
			push.outcome = OC_FOUND;
		end else begin
			push.outcome = OC_EMPTY;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			recent_q <= '0;
			phase_q  <= PH_KEY;
			esc_q    <= 1'b0;
			any_q    <= 1'b0;
		end else if (advance) begin
			if (last_in) begin
				recent_q <= '0;
				phase_q  <= PH_KEY;
				esc_q    <= 1'b0;
				any_q    <= 1'b0;
			end else begin
				recent_q <= {recent_q[55:0], byte_in};
				phase_q  <= phase_d;
				esc_q    <= esc_d;
				any_q    <= any_d;
			end
		end
	end

endmodule

`default_nettype wire

[rtl/core/jcfe_queue.sv]
// Small result queue that takes up to two results per cycle and gives one.
// Depends on jcfe_pkg for the result and push structs.
`default_nettype none

module jcfe_queue import jcfe_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  push_en,
	input  wire push_t push,
	input  wire logic  pop,
	output result_t    head_word,
	output logic       not_empty,
	output qstat_t     stat
);

	result_t            mem_q [QDEPTH];
	logic [QIDX_W-1:0]  head_q;
	logic [QIDX_W-1:0]  tail_q;
	logic [QCNT_W-1:0]  count_q;
	logic [QIDX_W-1:0]  tail_p1;
	logic [QCNT_W-1:0]  push_n;
	logic               do_pop;
	result_t            w_content;
	result_t            w_end;

	assign tail_p1   = tail_q + QIDX_W'(1);
	assign not_empty = (count_q != '0);
	assign do_pop    = pop && not_empty;
	assign head_word = mem_q[head_q];
	assign stat.count = count_q;
	// Room for two new words regardless of a pop in the same cycle.
	assign stat.room  = (count_q <= QCNT_W'(QDEPTH - 2));

	assign w_content = '{out_byte: push.content_byte, end_mark: 1'b0, outcome: OC_FOUND};
	assign w_end     = '{out_byte: 8'h00, end_mark: 1'b1, outcome: push.outcome};

	always_comb begin
		push_n = '0;
		if (push_en) begin
			push_n = QCNT_W'(push.content_valid) + QCNT_W'(push.end_valid);
		end
	end

	always_ff @(posedge clk) begin
		if (push_en) begin
			if (push.content_valid) begin
				mem_q[tail_q] <= w_content;
				if (push.end_valid) mem_q[tail_p1] <= w_end;
			end else if (push.end_valid) begin
				mem_q[tail_q] <= w_end;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
		end else begin
			if (do_pop) head_q <= head_q + QIDX_W'(1);
			tail_q  <= tail_q + push_n[QIDX_W-1:0];
			count_q <= count_q + push_n - QCNT_W'(do_pop);
		end
	end

endmodule

`default_nettype wire

[rtl/core/json_content_field_extractor.sv]
// JSON content field extractor: pulls the string value of the "content" key.
// Flow: an accepted word is held in the input stage register; when the queue has
// room it is parsed and its results are written to the queue, whose head is the output.
// Throughput: one byte per cycle; the byte flagged last yields a second word
// (the end marker), which the four-entry result queue absorbs. The input
// stalls only while the queue holds three or more words.
// Reset: arst_n clears the input stage valid bit, parser state and queue pointers.
// Depends on jcfe_pkg, jcfe_parser and jcfe_queue.
`default_nettype none

module json_content_field_extractor import jcfe_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [7:0] in_byte,
	input  wire logic       last,
	output logic            out_valid,
	input  wire logic       out_ready,
	output logic [7:0]      out_byte,
	output logic            end_mark,
	output logic [1:0]      outcome
);

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       last_s1;
	logic       advance;
	push_t      push;
	result_t    head_word;
	qstat_t     stat;

	assign advance  = valid_s1 && stat.room;
	assign in_ready = !valid_s1 || stat.room;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1 <= in_byte;
			last_s1 <= last;
		end
	end

	jcfe_parser u_parser (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.byte_in (byte_s1),
		.last_in (last_s1),
		.push    (push)
	);

	jcfe_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_en   (advance),
		.push      (push),
		.pop       (out_ready),
		.head_word (head_word),
		.not_empty (out_valid),
		.stat      (stat)
	);

	assign out_byte = head_word.out_byte;
	assign end_mark = head_word.end_mark;
	assign outcome  = head_word.outcome;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		stat.count <= QCNT_W'(QDEPTH))
		else $error("result queue overflow");

	a_stage_flow: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && valid_s1) |-> advance)
		else $error("input word accepted over a stalled stage");

	a_end_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && end_mark) |-> (out_byte == 8'h00))
		else $error("end marker carries a nonzero byte");

	a_content_code: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !end_mark) |-> (outcome == OC_FOUND))
		else $error("content word carries an outcome code");

endmodule

`default_nettype wire
